// ===== rtl/gche_pkg.sv =====
// shared types and constants for the gradient cubic hermite evaluator
// no dependencies
package gche_pkg;

  localparam int unsigned MaxKeys = 16;
  localparam int unsigned IdxW    = $clog2(MaxKeys);
  localparam int unsigned CntW    = IdxW + 1;
  localparam int unsigned ChanW   = 16;
  localparam int unsigned ColorW  = 4 * ChanW;

  // input opcodes
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } opcode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_KEY_COUNT  = 2'd0,
    REG_START_FLAT = 2'd1,
    REG_END_FLAT   = 2'd2,
    REG_NONE       = 2'd3
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SEARCH,
    S_FETCH,
    S_TDIV,
    S_DIV,
    S_D0,
    S_D1,
    S_PRE,
    S_MLO,
    S_MHI,
    S_ACC,
    S_EMIT
  } state_e;

  // where a finished quotient goes
  typedef enum logic [1:0] {
    DST_T,
    DST_D0,
    DST_D1
  } div_dst_e;

  // one channel out of a packed colour
  function automatic logic [ChanW-1:0] chan_of(input logic [ColorW-1:0] col,
                                               input logic [1:0] c);
    return col[c*ChanW +: ChanW];
  endfunction

endpackage

// ===== rtl/gradient_cubic_hermite_eval.sv =====
// gradient evaluator: key table, segment search and cubic hermite interpolation
// depends on gche_pkg
//
// channel | direction | transfer fields
// in      | sink      | opcode, key_index, key_time, key_red/green/blue/alpha, query_time
// out     | source    | out_red, out_green, out_blue, out_alpha
// cfg     | sink      | cfg_index (0 key_count, 1 start_flat, 2 end_flat), cfg_data
//
// a key write gives no result
// an evaluate outside the key range takes its result straight from the end key; an
// interior one does a segment search of one key per cycle, then uses one shared
// 32/16 restoring divider (one quotient bit per cycle) for the fraction and up
// to eight tangents, and one shared split multiplier (low half, then high half)
// the result sits in an output register, so a stalled output blocks only the
// next evaluate's final step; rst_ni clears control state and loads the
// default black-to-white two-key table
module gradient_cubic_hermite_eval (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic [3:0]                key_index_i,
  input  logic [15:0]               key_time_i,
  input  logic [15:0]               key_red_i,
  input  logic [15:0]               key_green_i,
  input  logic [15:0]               key_blue_i,
  input  logic [15:0]               key_alpha_i,
  input  logic [15:0]               query_time_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [15:0]               out_red_o,
  output logic [15:0]               out_green_o,
  output logic [15:0]               out_blue_o,
  output logic [15:0]               out_alpha_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [4:0]                cfg_data_i
);
  import gche_pkg::*;

  state_e state_q, state_d;

  // key table, one read address per cycle
  logic [ChanW-1:0]  times_q  [MaxKeys];
  logic [ColorW-1:0] colors_q [MaxKeys];
  logic [IdxW-1:0]   rd_idx;
  logic [ChanW-1:0]  rd_time;
  logic [ColorW-1:0] rd_color;

  logic [CntW-1:0] keycnt_q;
  logic            sflat_q, eflat_q;
  logic [CntW-1:0] n_eff;
  logic [IdxW-1:0] last_idx;

  logic [ChanW-1:0]  q_q;
  logic [IdxW-1:0]   pos_q;
  logic [1:0]        cnt_q;
  logic [1:0]        ch_q;
  logic [1:0]        ph_q;
  logic [ChanW-1:0]  kt_q [4];
  logic [ColorW-1:0] kc_q [4];

  // divider
  logic [31:0]    dvd_q;
  logic [15:0]    rem_q, dvs_q;
  logic           dneg_q;
  logic [4:0]     dcnt_q;
  div_dst_e       ddst_q;
  logic [16:0]    rem_sh;
  logic           ge;
  logic [15:0]    rem_nx;
  logic [31:0]    quo_nx;
  logic signed [32:0] quo_s;

  // polynomial datapath
  logic [16:0]        t_q;
  logic signed [32:0] d0_q, d1_q;
  logic signed [39:0] w_q;
  logic [36:0]        plo_q;
  logic signed [57:0] p_q;
  logic [15:0]        res_q [4];

  logic              in_acc, out_acc;
  logic              out_valid_q;
  logic [15:0]       out_q [4];

  // tangent operands
  logic [15:0]        tdif, tdif_g;
  logic signed [16:0] dif, tg_diff, tg_span;
  logic [15:0]        mag_diff, mag_span;
  logic [31:0]        tg_prod;
  logic               tg_neg;
  logic [15:0]        c0;
  logic               first_seg, last_seg, found;

  logic signed [39:0] a_val, b_val, addend, tr, sum;
  logic [36:0]        lo_prod;
  logic signed [37:0] hi_prod;

  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_q && out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // effective key count, clamped to 2..MaxKeys
  always_comb begin
    if (keycnt_q < CntW'(2)) n_eff = CntW'(2);
    else if (keycnt_q > CntW'(MaxKeys)) n_eff = CntW'(MaxKeys);
    else n_eff = keycnt_q;
  end
  assign last_idx = IdxW'(n_eff - CntW'(1));

  // table read address
  always_comb begin
    unique case (state_q)
      S_FIRST:  rd_idx = '0;
      S_LAST:   rd_idx = last_idx;
      S_SEARCH: rd_idx = pos_q + IdxW'(1);
      S_FETCH:  rd_idx = pos_q - IdxW'(1) + IdxW'(cnt_q);
      default:  rd_idx = '0;
    endcase
  end
  assign rd_time  = times_q[rd_idx];
  assign rd_color = colors_q[rd_idx];

  assign found     = ((CntW'(pos_q) + CntW'(2)) >= n_eff) || (q_q <= rd_time);
  assign first_seg = (pos_q == '0);
  assign last_seg  = ((CntW'(pos_q) + CntW'(2)) == n_eff);

  // divider step
  assign rem_sh = {rem_q, dvd_q[31]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = ge ? 16'(rem_sh - {1'b0, dvs_q}) : rem_sh[15:0];
  assign quo_nx = {dvd_q[30:0], ge};
  assign quo_s  = dneg_q ? -$signed({1'b0, quo_nx}) : $signed({1'b0, quo_nx});

  // segment values for the current channel
  always_comb begin
    tdif     = kt_q[2] - kt_q[1];
    tdif_g   = (tdif == '0) ? 16'd1 : tdif;
    c0       = chan_of(kc_q[1], ch_q);
    dif      = $signed({1'b0, chan_of(kc_q[2], ch_q)}) - $signed({1'b0, c0});
    if (state_q == S_D1) begin
      tg_diff = $signed({1'b0, chan_of(kc_q[3], ch_q)}) - $signed({1'b0, c0});
      tg_span = $signed({1'b0, kt_q[3]}) - $signed({1'b0, kt_q[1]});
    end else begin
      tg_diff = $signed({1'b0, chan_of(kc_q[2], ch_q)})
              - $signed({1'b0, chan_of(kc_q[0], ch_q)});
      tg_span = $signed({1'b0, kt_q[2]}) - $signed({1'b0, kt_q[0]});
    end
    mag_diff = tg_diff[16] ? 16'(-tg_diff) : tg_diff[15:0];
    mag_span = tg_span[16] ? 16'(-tg_span) : tg_span[15:0];
    tg_prod  = tdif_g * mag_diff;
    tg_neg   = tg_diff[16] ^ tg_span[16];
  end

  // hermite coefficients and the accumulate step
  always_comb begin
    a_val   = 40'(d0_q) + 40'(d1_q) - (40'(dif) <<< 1);
    b_val   = 40'(dif) * 40'sd3 - (40'(d0_q) <<< 1) - 40'(d1_q);
    lo_prod = w_q[19:0] * t_q;
    hi_prod = $signed(w_q[39:20]) * $signed({1'b0, t_q});
    tr      = 40'((p_q + (p_q[57] ? 58'sd65535 : 58'sd0)) >>> 16);
    unique case (ph_q)
      2'd0:    addend = b_val;
      2'd1:    addend = 40'(d0_q);
      default: addend = $signed({24'd0, c0});
    endcase
    sum = tr + addend;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc && opcode_i == OP_EVAL) state_d = S_FIRST;
      S_FIRST:  state_d = (q_q <= rd_time) ? S_EMIT : S_LAST;
      S_LAST:   state_d = (q_q >= rd_time) ? S_EMIT : S_SEARCH;
      S_SEARCH: if (found) state_d = S_FETCH;
      S_FETCH:  if (cnt_q == 2'd3) state_d = S_TDIV;
      S_TDIV:   state_d = S_DIV;
      S_DIV: begin
        if (dcnt_q == '0) begin
          unique case (ddst_q)
            DST_T:   state_d = S_D0;
            DST_D0:  state_d = S_D1;
            default: state_d = S_PRE;
          endcase
        end
      end
      S_D0: begin
        if (first_seg || tg_span == '0) state_d = S_D1;
        else state_d = S_DIV;
      end
      S_D1: begin
        if (last_seg || tg_span == '0) state_d = S_PRE;
        else state_d = S_DIV;
      end
      S_PRE:    state_d = S_MLO;
      S_MLO:    state_d = S_MHI;
      S_MHI:    state_d = S_ACC;
      S_ACC: begin
        if (ph_q != 2'd2) state_d = S_MLO;
        else if (ch_q == 2'd3) state_d = S_EMIT;
        else state_d = S_D0;
      end
      S_EMIT:   if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      keycnt_q <= CntW'(2);
      sflat_q  <= 1'b0;
      eflat_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_KEY_COUNT:  keycnt_q <= cfg_data_i;
          REG_START_FLAT: sflat_q  <= cfg_data_i[0];
          REG_END_FLAT:   eflat_q  <= cfg_data_i[0];
          default:        ;
        endcase
      end
    end
  end

  // key table with its default contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxKeys; i++) begin
        times_q[i]  <= '0;
        colors_q[i] <= '0;
      end
      times_q[1]  <= '1;
      colors_q[0] <= {16'hFFFF, 48'd0};
      colors_q[1] <= '1;
    end else if (in_acc && opcode_i == OP_WRITE) begin
      times_q[key_index_i]  <= key_time_i;
      colors_q[key_index_i] <= {key_alpha_i, key_blue_i, key_green_i, key_red_i};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_EMIT && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && (!out_valid_q || out_ready_i)) begin
      for (int c = 0; c < 4; c++) out_q[c] <= res_q[c];
    end
  end

  // sequencer datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        q_q <= query_time_i;
      end
      S_FIRST, S_LAST: begin
        for (int c = 0; c < 4; c++) res_q[c] <= chan_of(rd_color, 2'(c));
        pos_q <= '0;
      end
      S_SEARCH: begin
        if (!found) pos_q <= pos_q + IdxW'(1);
        cnt_q <= '0;
      end
      S_FETCH: begin
        kt_q[cnt_q] <= rd_time;
        kc_q[cnt_q] <= rd_color;
        cnt_q       <= cnt_q + 2'd1;
      end
      S_TDIV: begin
        dvd_q  <= {q_q - kt_q[1], 16'd0};
        dvs_q  <= tdif_g;
        rem_q  <= '0;
        dneg_q <= 1'b0;
        dcnt_q <= 5'd31;
        ddst_q <= DST_T;
        ch_q   <= '0;
      end
      S_DIV: begin
        dvd_q  <= quo_nx;
        rem_q  <= rem_nx;
        dcnt_q <= dcnt_q - 5'd1;
        if (dcnt_q == '0) begin
          unique case (ddst_q)
            DST_T:   t_q  <= quo_nx[16:0];
            DST_D0:  d0_q <= quo_s;
            default: d1_q <= quo_s;
          endcase
        end
      end
      S_D0, S_D1: begin
        dvd_q  <= tg_prod;
        dvs_q  <= mag_span;
        rem_q  <= '0;
        dneg_q <= tg_neg;
        dcnt_q <= 5'd31;
        if (state_q == S_D0) begin
          ddst_q <= DST_D0;
          if (first_seg) d0_q <= sflat_q ? '0 : 33'(dif);
          else if (tg_span == '0) d0_q <= '0;
        end else begin
          ddst_q <= DST_D1;
          if (last_seg) d1_q <= eflat_q ? '0 : 33'(dif);
          else if (tg_span == '0) d1_q <= '0;
        end
      end
      S_PRE: begin
        w_q  <= a_val;
        ph_q <= '0;
      end
      S_MLO: begin
        plo_q <= lo_prod;
      end
      S_MHI: begin
        p_q <= (58'(hi_prod) <<< 20) + $signed({21'd0, plo_q});
      end
      S_ACC: begin
        w_q  <= sum;
        ph_q <= ph_q + 2'd1;
        if (ph_q == 2'd2) begin
          if (sum < 0) res_q[ch_q] <= '0;
          else if (sum > 40'sd65535) res_q[ch_q] <= '1;
          else res_q[ch_q] <= sum[15:0];
          ch_q <= ch_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];
  assign out_alpha_o = out_q[3];

endmodule
